/* design/u16rx_pkg.sv */
// Shared types, constants and helper functions of the UTF-16 printable run extractor.
package u16rx_pkg;

    localparam int MAX_MIN_LEN = 16;
    localparam int CNT_W       = $clog2(MAX_MIN_LEN + 1);
    localparam int IDX_W       = $clog2(MAX_MIN_LEN);
    localparam int CP_W        = 21;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // lane event codes
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    // result kinds
    localparam logic KIND_CP  = 1'b0;
    localparam logic KIND_END = 1'b1;

    // configuration register indexes
    localparam logic REG_MIN_LEN     = 1'b0;
    localparam logic REG_ENDIAN_MODE = 1'b1;

    // endian modes
    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_LITTLE = 2'd1;
    localparam logic [1:0] MODE_BIG    = 2'd2;
    localparam logic [1:0] MODE_BOTH   = 2'd3;

    typedef struct packed {
        logic            pre_end;   // pair broken: end run before the main event
        logic [1:0]      op;
        logic [CP_W-1:0] cp;
    } lane_ev_t;

    typedef struct packed {
        lane_ev_t [1:0] ev;
        logic           last;
    } rec_t;

    typedef struct packed {
        logic            lane;
        logic            kind;
        logic [CP_W-1:0] code_point;
        logic [31:0]     utf8_word;
        logic [2:0]      utf8_count;
    } res_t;

    function automatic res_t make_cp(logic lane, logic [CP_W-1:0] cp);
        res_t r;
        r.lane       = lane;
        r.kind       = KIND_CP;
        r.code_point = cp;
        if (cp <= 21'h7F) begin
            r.utf8_word  = {cp[7:0], 24'h0};
            r.utf8_count = 3'd1;
        end
        else if (cp <= 21'h7FF) begin
            r.utf8_word  = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
            r.utf8_count = 3'd2;
        end
        else if (cp <= 21'hFFFF) begin
            r.utf8_word  = {4'hE, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
            r.utf8_count = 3'd3;
        end
        else begin
            r.utf8_word  = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                            2'b10, cp[5:0]};
            r.utf8_count = 3'd4;
        end
        return r;
    endfunction

    function automatic res_t make_end(logic lane);
        res_t r;
        r.lane       = lane;
        r.kind       = KIND_END;
        r.code_point = '0;
        r.utf8_word  = '0;
        r.utf8_count = '0;
        return r;
    endfunction

endpackage

/* design/u16rx_front.sv */
// Front end: pairs bytes into units, picks lanes, joins surrogates, classifies code points.
module u16rx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [1:0]        endian_mode,
    input  logic              q_full,
    output logic              rec_valid,
    output u16rx_pkg::rec_t   rec
);

    typedef struct packed {
        u16rx_pkg::lane_ev_t ev;
        logic                pv;
        logic [9:0]          hi;
    } dec_t;

    function automatic logic printable(logic [u16rx_pkg::CP_W-1:0] cp);
        logic bad;
        bad = (cp < 21'h20) || (cp inside {[21'h7F:21'h9F]}) || (cp > 21'h10FFFF)
            || (cp inside {[21'hD800:21'hDFFF]}) || (cp[15:1] == 15'h7FFF)
            || (cp inside {[21'hFDD0:21'hFDEF]});
        return !bad;
    endfunction

    function automatic dec_t decode(logic pv, logic [9:0] hi, logic [15:0] u);
        dec_t d;
        logic [u16rx_pkg::CP_W-1:0] cp;
        d.ev.pre_end = 1'b0;
        d.ev.op      = u16rx_pkg::OP_NONE;
        d.ev.cp      = '0;
        d.pv         = 1'b0;
        d.hi         = hi;
        if (pv && (u inside {[16'hDC00:16'hDFFF]})) begin
            cp      = 21'h10000 + {1'b0, hi, u[9:0]};
            d.ev.cp = cp;
            d.ev.op = printable(cp) ? u16rx_pkg::OP_PUSH : u16rx_pkg::OP_END;
        end
        else begin
            d.ev.pre_end = pv;
            cp           = {5'b0, u};
            if (u == 16'hFEFF) begin
                d.ev.op = u16rx_pkg::OP_END;
            end
            else if (u inside {[16'hD800:16'hDBFF]}) begin
                d.pv = 1'b1;
                d.hi = u[9:0];
            end
            else if (u inside {[16'hDC00:16'hDFFF]}) begin
                d.ev.op = u16rx_pkg::OP_END;
            end
            else begin
                d.ev.cp = cp;
                d.ev.op = printable(cp) ? u16rx_pkg::OP_PUSH : u16rx_pkg::OP_END;
            end
        end
        return d;
    endfunction

    logic             phase_reg;
    logic [7:0]       held_reg;
    logic             seen_reg;
    logic [1:0]       lanes_reg;
    logic [1:0]       pv_reg;
    logic [1:0][9:0]  hi_reg;
    logic [1:0]       lanes_now;
    logic             accept;
    dec_t [1:0]       dec;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (seen_reg) begin
            lanes_now = lanes_reg;
        end
        else begin
            case (endian_mode)
                u16rx_pkg::MODE_LITTLE: lanes_now = 2'b01;
                u16rx_pkg::MODE_BIG:    lanes_now = 2'b10;
                u16rx_pkg::MODE_BOTH:   lanes_now = 2'b11;
                default:
                begin
                    if (held_reg == 8'hFF && data_byte == 8'hFE)
                        lanes_now = 2'b01;
                    else if (held_reg == 8'hFE && data_byte == 8'hFF)
                        lanes_now = 2'b10;
                    else
                        lanes_now = 2'b11;
                end
            endcase
        end
        dec[0] = decode(pv_reg[0], hi_reg[0], {data_byte, held_reg});
        dec[1] = decode(pv_reg[1], hi_reg[1], {held_reg, data_byte});
        for (int l = 0; l < 2; l++) begin
            if (phase_reg && lanes_now[l]) begin
                rec.ev[l] = dec[l].ev;
            end
            else begin
                rec.ev[l].pre_end = 1'b0;
                rec.ev[l].op      = u16rx_pkg::OP_NONE;
                rec.ev[l].cp      = '0;
            end
        end
        rec.last  = last_byte;
        rec_valid = accept && (phase_reg || last_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= 1'b0;
            seen_reg  <= 1'b0;
            lanes_reg <= 2'b11;
            pv_reg    <= 2'b00;
        end
        else if (accept) begin
            if (last_byte) begin
                phase_reg <= 1'b0;
                seen_reg  <= 1'b0;
                lanes_reg <= 2'b11;
                pv_reg    <= 2'b00;
            end
            else if (!phase_reg) begin
                phase_reg <= 1'b1;
            end
            else begin
                phase_reg <= 1'b0;
                seen_reg  <= 1'b1;
                lanes_reg <= lanes_now;
                for (int l = 0; l < 2; l++) begin
                    if (lanes_now[l])
                        pv_reg[l] <= dec[l].pv;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !phase_reg)
            held_reg <= data_byte;
        if (accept && phase_reg) begin
            for (int l = 0; l < 2; l++) begin
                if (lanes_now[l])
                    hi_reg[l] <= dec[l].hi;
            end
        end
    end

endmodule

/* design/u16rx_fifo.sv */
// Short queue of per-unit event records between front and back end.
module u16rx_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  u16rx_pkg::rec_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output u16rx_pkg::rec_t rd_data
);

    u16rx_pkg::rec_t                  mem_reg [u16rx_pkg::Q_DEPTH];
    logic [u16rx_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [u16rx_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [u16rx_pkg::Q_CNT_W-1:0]    count_reg;
    logic                             do_wr;
    logic                             do_rd;

    assign full     = (count_reg == u16rx_pkg::Q_CNT_W'(u16rx_pkg::Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* design/u16rx_back.sv */
// Back end: run buffering, release bursts, run-end markers and output staging.
module u16rx_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [u16rx_pkg::CNT_W-1:0] min_len,
    input  logic                        rec_valid,
    input  u16rx_pkg::rec_t             rec,
    output logic                        rec_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output u16rx_pkg::res_t             m_res,
    output logic                        m_final
);

    localparam int BUF_N = 2 * u16rx_pkg::MAX_MIN_LEN;

    logic [u16rx_pkg::CP_W-1:0]              buf_reg [BUF_N];
    logic                                    busy_reg;
    logic [5:0]                              mask_reg;
    u16rx_pkg::rec_t                         cur_reg;
    logic                                    rel_reg;
    logic                                    rel_lane_reg;
    logic [u16rx_pkg::IDX_W-1:0]             ri_reg;
    logic [u16rx_pkg::IDX_W-1:0]             rel_last_reg;
    logic [1:0][u16rx_pkg::CNT_W-1:0]        cnt_reg;
    logic [1:0]                              released_reg;
    logic                                    hold_valid_reg;
    u16rx_pkg::res_t                         hold_reg;
    logic                                    ovalid_reg;
    u16rx_pkg::res_t                         out_reg;
    logic                                    ofinal_reg;

    logic                                    can_move;
    logic                                    rel_step;
    logic                                    op_step;
    logic                                    end_step;
    logic [5:0]                              sel;
    logic                                    found;
    logic                                    op_lane;
    logic                                    op_push;
    logic [u16rx_pkg::CP_W-1:0]              op_cp;
    logic [u16rx_pkg::IDX_W-1:0]             wr_idx;
    logic [u16rx_pkg::CNT_W-1:0]             cnt_new;
    logic [u16rx_pkg::CNT_W-1:0]             eff_len;
    logic                                    start_rel;
    logic                                    buf_wr;
    logic                                    emit;
    u16rx_pkg::res_t                         emit_res;
    logic                                    flush;
    logic [5:0]                              mask_next;

    assign can_move = !ovalid_reg || m_tready;
    assign rel_step = can_move && busy_reg && rel_reg;
    assign op_step  = can_move && busy_reg && !rel_reg && (mask_reg != '0);
    assign end_step = can_move && busy_reg && !rel_reg && (mask_reg == '0);
    assign rec_pop  = rec_valid && (!busy_reg || end_step);
    assign flush    = end_step && hold_valid_reg;

    always_comb
    begin
        sel   = '0;
        found = 1'b0;
        for (int i = 0; i < 6; i++) begin
            if (mask_reg[i] && !found) begin
                sel[i] = 1'b1;
                found  = 1'b1;
            end
        end
        op_lane = sel[2] || sel[3] || sel[5];
        op_push = (sel[1] && cur_reg.ev[0].op == u16rx_pkg::OP_PUSH)
               || (sel[3] && cur_reg.ev[1].op == u16rx_pkg::OP_PUSH);
        op_cp   = op_lane ? cur_reg.ev[1].cp : cur_reg.ev[0].cp;

        if (min_len == '0)
            eff_len = u16rx_pkg::CNT_W'(1);
        else if (min_len > u16rx_pkg::CNT_W'(u16rx_pkg::MAX_MIN_LEN))
            eff_len = u16rx_pkg::CNT_W'(u16rx_pkg::MAX_MIN_LEN);
        else
            eff_len = min_len;

        if (cnt_reg[op_lane] >= u16rx_pkg::CNT_W'(u16rx_pkg::MAX_MIN_LEN))
            wr_idx = u16rx_pkg::IDX_W'(u16rx_pkg::MAX_MIN_LEN - 1);
        else
            wr_idx = cnt_reg[op_lane][u16rx_pkg::IDX_W-1:0];
        cnt_new   = u16rx_pkg::CNT_W'(wr_idx) + 1'b1;
        start_rel = (cnt_new >= eff_len);
        buf_wr    = op_step && op_push && !released_reg[op_lane];

        emit = rel_step || (op_step && released_reg[op_lane]);
        if (rel_step)
            emit_res = u16rx_pkg::make_cp(rel_lane_reg, buf_reg[{rel_lane_reg, ri_reg}]);
        else if (op_push)
            emit_res = u16rx_pkg::make_cp(op_lane, op_cp);
        else
            emit_res = u16rx_pkg::make_end(op_lane);

        mask_next[0] = rec.ev[0].pre_end;
        mask_next[1] = (rec.ev[0].op != u16rx_pkg::OP_NONE);
        mask_next[2] = rec.ev[1].pre_end;
        mask_next[3] = (rec.ev[1].op != u16rx_pkg::OP_NONE);
        mask_next[4] = rec.last;
        mask_next[5] = rec.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg       <= 1'b0;
            mask_reg       <= '0;
            rel_reg        <= 1'b0;
            cnt_reg        <= '0;
            released_reg   <= '0;
            hold_valid_reg <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else begin
            if (emit) begin
                ovalid_reg     <= hold_valid_reg;
                hold_valid_reg <= 1'b1;
            end
            else if (flush) begin
                ovalid_reg     <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
            else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end

            if (rec_pop) begin
                busy_reg <= 1'b1;
                mask_reg <= mask_next;
            end
            else if (end_step) begin
                busy_reg <= 1'b0;
            end
            else if (op_step) begin
                mask_reg <= mask_reg & ~sel;
            end

            if (rel_step && ri_reg == rel_last_reg)
                rel_reg <= 1'b0;

            if (op_step) begin
                if (!op_push) begin
                    cnt_reg[op_lane]      <= '0;
                    released_reg[op_lane] <= 1'b0;
                end
                else if (!released_reg[op_lane]) begin
                    cnt_reg[op_lane] <= cnt_new;
                    if (start_rel) begin
                        released_reg[op_lane] <= 1'b1;
                        rel_reg               <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_wr)
            buf_reg[{op_lane, wr_idx}] <= op_cp;
        if (rec_pop)
            cur_reg <= rec;
        if (buf_wr && start_rel) begin
            rel_lane_reg <= op_lane;
            ri_reg       <= '0;
            rel_last_reg <= wr_idx;
        end
        else if (rel_step) begin
            ri_reg <= ri_reg + 1'b1;
        end
        if (emit) begin
            hold_reg   <= emit_res;
            out_reg    <= hold_reg;
            ofinal_reg <= 1'b0;
        end
        else if (flush) begin
            out_reg    <= hold_reg;
            ofinal_reg <= 1'b1;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_res    = out_reg;
    assign m_final  = ofinal_reg;

endmodule

/* design/utf16_printable_run_extractor.sv */
// Top level of the UTF-16 printable run extractor: config registers and stream ports.
//
//  channel  dir  beat contents
//  -------  ---  -----------------------------------------------------------------
//  s_*      in   tdata[7:0] data_byte; tlast last_byte
//  m_*      out  tdata code_point/utf8_word/utf8_count; tuser lane/kind; tlast final
//  cfg_*    in   cfg_we, cfg_addr (0 min_len, 1 endian_mode), cfg_data[4:0]
//
// The front end takes one byte per cycle while the four-entry record queue has room.
// The back end handles each run event and each buffered code point of a release burst
// (up to 16) as a step of its own, and closes out each record with a final step.
// Reset (rst_n low) clears stream state; min_len returns to 4, endian_mode to 3.
// A stalled m_tready holds the output beat and, once the queue fills, s_tready.
module utf16_printable_run_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [20:0] code_point, [52:21] utf8_word, [55:53] utf8_count
    output logic [1:0]  m_tuser,   // [0] lane, [1] kind
    output logic        m_tlast,   // final_of_item
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [4:0]  cfg_data
);

    logic [u16rx_pkg::CNT_W-1:0] min_len_reg;
    logic [1:0]                  endian_mode_reg;

    logic            fr_valid;
    u16rx_pkg::rec_t fr_rec;
    logic            q_full;
    logic            q_valid;
    u16rx_pkg::rec_t q_rec;
    logic            q_pop;
    u16rx_pkg::res_t res;

    // config writes take effect at once; issue them only while idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_len_reg     <= u16rx_pkg::CNT_W'(4);
            endian_mode_reg <= u16rx_pkg::MODE_BOTH;
        end
        else if (cfg_we) begin
            case (cfg_addr)
                u16rx_pkg::REG_MIN_LEN:     min_len_reg     <= cfg_data;
                u16rx_pkg::REG_ENDIAN_MODE: endian_mode_reg <= cfg_data[1:0];
                default:                    ;
            endcase
        end
    end

    u16rx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .data_byte   (s_tdata),
        .last_byte   (s_tlast),
        .endian_mode (endian_mode_reg),
        .q_full      (q_full),
        .rec_valid   (fr_valid),
        .rec         (fr_rec)
    );

    u16rx_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fr_valid),
        .wr_data  (fr_rec),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rec)
    );

    u16rx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .min_len   (min_len_reg),
        .rec_valid (q_valid),
        .rec       (q_rec),
        .rec_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (res),
        .m_final   (m_tlast)
    );

    assign m_tdata = {res.utf8_count, res.utf8_word, res.code_point};
    assign m_tuser = {res.kind, res.lane};

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the UTF-16 printable run extractor.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES    = 200;    // wait after the last expected beat, for the back end to go quiet

    typedef struct {
        bit          lane;
        bit          kind;
        logic [20:0] code_point;
        logic [31:0] utf8_word;
        logic [2:0]  utf8_count;
        bit          final_of_item;
    } decoded_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] data_byte
    logic        s_tlast = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // [20:0] code_point, [52:21] utf8_word, [55:53] utf8_count
    logic [1:0]  m_tuser;          // [0] lane, [1] kind
    logic        m_tlast;          // final_of_item
    logic        cfg_we = 1'b0;
    logic        cfg_addr = u16rx_pkg::REG_MIN_LEN;
    logic [4:0]  cfg_data = '0;

    utf16_printable_run_extractor DUT (.*);

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: our own copy of the block's stream state and registers
    // ---------------------------------------------------------------
    decoded_beat_t expected_beats[$];
    logic [4:0]    min_len_reg = 5'd4;
    logic [1:0]    mode_reg = u16rx_pkg::MODE_BOTH;
    bit            odd_byte_held;
    logic [7:0]    held_byte;
    bit            lanes_chosen;
    logic [1:0]    lane_mask;
    logic [10:0]   high_pending [2];   // bit 10: high surrogate waiting
    int            run_len [2];
    bit            run_out [2];        // run already released
    logic [20:0]   run_store [2][u16rx_pkg::MAX_MIN_LEN];

    int  mismatches = 0;
    int  bytes_sent = 0;
    bit  gaps_on = 1'b1;               // random idling on both sides
    int  hold_req = 0;                 // bumped by a test to ask for a long receiver stall
    int  hold_seen = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;

    function automatic bit is_printable(logic [20:0] cp);
        if (cp < 21'h20 || (cp >= 21'h7F && cp <= 21'h9F)) return 1'b0;
        if (cp > 21'h10FFFF) return 1'b0;
        if (cp >= 21'hD800 && cp <= 21'hDFFF) return 1'b0;
        if (cp[15:1] == 15'h7FFF) return 1'b0;       // U+xxFFFE / U+xxFFFF
        if (cp >= 21'hFDD0 && cp <= 21'hFDEF) return 1'b0;
        return 1'b1;
    endfunction

    task automatic queue_beat(bit lane, bit kind, logic [20:0] cp);
        decoded_beat_t e;
        e.lane = lane;
        e.kind = kind;
        e.final_of_item = 1'b0;
        e.code_point = (kind == u16rx_pkg::KIND_END) ? 21'h0 : cp;
        e.utf8_word = '0;
        e.utf8_count = '0;
        if (kind == u16rx_pkg::KIND_CP)
        begin
            if (cp < 21'h80)
            begin
                e.utf8_word = 32'(cp) << 24;
                e.utf8_count = 3'd1;
            end
            else if (cp < 21'h800)
            begin
                e.utf8_word = ((32'hC0 | (32'(cp) >> 6)) << 24)
                            | ((32'h80 | (32'(cp) & 32'h3F)) << 16);
                e.utf8_count = 3'd2;
            end
            else if (cp < 21'h10000)
            begin
                e.utf8_word = ((32'hE0 | (32'(cp) >> 12)) << 24)
                            | ((32'h80 | ((32'(cp) >> 6) & 32'h3F)) << 16)
                            | ((32'h80 | (32'(cp) & 32'h3F)) << 8);
                e.utf8_count = 3'd3;
            end
            else
            begin
                e.utf8_word = ((32'hF0 | ((32'(cp) >> 18) & 32'h7)) << 24)
                            | ((32'h80 | ((32'(cp) >> 12) & 32'h3F)) << 16)
                            | ((32'h80 | ((32'(cp) >> 6) & 32'h3F)) << 8)
                            | (32'h80 | (32'(cp) & 32'h3F));
                e.utf8_count = 3'd4;
            end
        end
        expected_beats = {expected_beats, e};
    endtask

    task automatic close_run(int l);
        if (run_out[l]) queue_beat(l[0], u16rx_pkg::KIND_END, 21'h0);
        run_len[l] = 0;
        run_out[l] = 1'b0;
    endtask

    task automatic add_code_point(int l, logic [20:0] cp);
        int need;
        if (!is_printable(cp))
        begin
            close_run(l);
            return;
        end
        if (run_out[l])
        begin
            queue_beat(l[0], u16rx_pkg::KIND_CP, cp);
            return;
        end
        if (run_len[l] >= u16rx_pkg::MAX_MIN_LEN) run_len[l] = u16rx_pkg::MAX_MIN_LEN - 1;
        run_store[l][run_len[l]] = cp;
        run_len[l]++;
        // min_len of zero behaves as 1, above the buffer depth as the depth
        if (min_len_reg == 0)
            need = 1;
        else if (min_len_reg > u16rx_pkg::MAX_MIN_LEN)
            need = u16rx_pkg::MAX_MIN_LEN;
        else
            need = int'(min_len_reg);
        if (run_len[l] >= need)
        begin
            for (int i = 0; i < run_len[l]; i++)
                queue_beat(l[0], u16rx_pkg::KIND_CP, run_store[l][i]);
            run_out[l] = 1'b1;
        end
    endtask

    task automatic decode_unit(int l, logic [15:0] u);
        if (high_pending[l][10])
        begin
            logic [9:0] hi;
            hi = high_pending[l][9:0];
            high_pending[l] = '0;
            if (u >= 16'hDC00 && u <= 16'hDFFF)
            begin
                add_code_point(l, 21'h10000 + {1'b0, hi, u[9:0]});
                return;
            end
            close_run(l);   // broken pair: the unit is decoded afresh below
        end
        if (u == 16'hFEFF) close_run(l);
        else if (u >= 16'hD800 && u <= 16'hDBFF) high_pending[l] = {1'b1, u[9:0]};
        else if (u >= 16'hDC00 && u <= 16'hDFFF) close_run(l);
        else add_code_point(l, {5'd0, u});
    endtask

    task automatic clear_stream();
        odd_byte_held = 1'b0;
        held_byte = '0;
        lanes_chosen = 1'b0;
        lane_mask = 2'b11;
        high_pending[0] = '0;
        high_pending[1] = '0;
        run_len[0] = 0;
        run_len[1] = 0;
        run_out[0] = 1'b0;
        run_out[1] = 1'b0;
    endtask

    task automatic predict_byte(logic [7:0] b, bit last);
        int beats_prior;
        beats_prior = expected_beats.size();
        if (!odd_byte_held)
        begin
            held_byte = b;
            odd_byte_held = 1'b1;
        end
        else
        begin
            odd_byte_held = 1'b0;
            if (!lanes_chosen)
            begin
                lanes_chosen = 1'b1;
                case (mode_reg)
                    u16rx_pkg::MODE_LITTLE: lane_mask = 2'b01;
                    u16rx_pkg::MODE_BIG:    lane_mask = 2'b10;
                    u16rx_pkg::MODE_BOTH:   lane_mask = 2'b11;
                    default:
                        if (held_byte == 8'hFF && b == 8'hFE) lane_mask = 2'b01;
                        else if (held_byte == 8'hFE && b == 8'hFF) lane_mask = 2'b10;
                        else lane_mask = 2'b11;
                endcase
            end
            if (lane_mask[0]) decode_unit(0, {b, held_byte});
            if (lane_mask[1]) decode_unit(1, {held_byte, b});
        end
        if (last)
        begin
            close_run(0);
            close_run(1);
            clear_stream();
        end
        if (expected_beats.size() > beats_prior)
            expected_beats[expected_beats.size() - 1].final_of_item = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold when a test asks
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= 300;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Output checker: each beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            decoded_beat_t e;
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: tuser=%b tdata=%h tlast=%b",
                             m_tuser, m_tdata, m_tlast);
            end
            else
            begin
                e = expected_beats.pop_front();
                if (m_tuser[0] !== e.lane || m_tuser[1] !== e.kind
                    || m_tdata[20:0] !== e.code_point || m_tdata[52:21] !== e.utf8_word
                    || m_tdata[55:53] !== e.utf8_count || m_tlast !== e.final_of_item)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp lane=%0d kind=%0d cp=%h utf8=%h/%0d last=%0d",
                                 e.lane, e.kind, e.code_point, e.utf8_word, e.utf8_count,
                                 e.final_of_item,
                                 ", got lane=%0d kind=%0d cp=%h utf8=%h/%0d last=%0d",
                                 m_tuser[0], m_tuser[1], m_tdata[20:0],
                                 m_tdata[52:21], m_tdata[55:53], m_tlast);
                end
            end
        end
    end

    // Watchdog: ends a hung run
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d beats outstanding", expected_beats.size());
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, bit last);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_unit(logic [15:0] u, bit big, bit last);
        if (big)
        begin
            send_byte(u[15:8], 1'b0);
            send_byte(u[7:0], last);
        end
        else
        begin
            send_byte(u[7:0], 1'b0);
            send_byte(u[15:8], last);
        end
    endtask

    // Pause the sender until every expected beat is out, then idle for TAIL_CYCLES
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (expected_beats.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Only call while idle (after drain)
    task automatic write_reg(logic addr, logic [4:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == u16rx_pkg::REG_MIN_LEN) min_len_reg = value;
        else mode_reg = value[1:0];
        @(posedge clk);
    endtask

    task automatic send_text(logic [15:0] units [], bit big);
        foreach (units[i]) send_unit(units[i], big, i == units.size() - 1);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Default registers: plain ASCII run, controls, the limits of the DEL/C1 range, noncharacters, BOM
    task automatic test_run_boundaries();
        send_text({16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h001F, 16'h00A0,
                   16'h07FF, 16'h0800, 16'hFFFD, 16'h007F, 16'h0020, 16'h007E, 16'h009F,
                   16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'hFDD0, 16'hFEFF, 16'hFFFE},
                  1'b0);
    endtask

    // Surrogate joining, stray low half, unpaired high half, odd final byte
    task automatic test_surrogates();
        write_reg(u16rx_pkg::REG_MIN_LEN, 5'd2);
        write_reg(u16rx_pkg::REG_ENDIAN_MODE, 5'(u16rx_pkg::MODE_LITTLE));
        send_text({16'hD83D, 16'hDE00, 16'hDBFF, 16'hDFFF, 16'hD800, 16'hDC00, 16'hDC00,
                   16'h0041, 16'hD801, 16'h0042, 16'h0043, 16'hDBFF, 16'hDFFE, 16'hD800},
                  1'b0);
        send_unit(16'h0041, 1'b0, 1'b0);
        send_unit(16'h0042, 1'b0, 1'b0);
        send_byte(8'h43, 1'b1);             // lone byte at stream end is dropped
        drain();
    endtask

    // Lane selection: forced lanes and byte-order mark detection in auto mode
    task automatic test_lane_select();
        write_reg(u16rx_pkg::REG_ENDIAN_MODE, 5'(u16rx_pkg::MODE_BIG));
        send_text({16'h0048, 16'h0049, 16'h004A}, 1'b1);
        drain();
        write_reg(u16rx_pkg::REG_ENDIAN_MODE, 5'(u16rx_pkg::MODE_AUTO));
        send_text({16'hFEFF, 16'h0050, 16'h0051, 16'h0052}, 1'b0);  // FF FE: little
        send_text({16'hFEFF, 16'h0053, 16'h0054, 16'h0055}, 1'b1);  // FE FF: big
        send_text({16'h4100, 16'h4200, 16'h4300}, 1'b0);            // no mark: both
        drain();
    endtask

    // min_len extremes, including zero and values beyond the buffer depth
    task automatic test_min_len_extremes();
        logic [4:0] lens [4] = '{5'd0, 5'd1, 5'd16, 5'd31};
        write_reg(u16rx_pkg::REG_ENDIAN_MODE, 5'(u16rx_pkg::MODE_BOTH));
        foreach (lens[k])
        begin
            write_reg(u16rx_pkg::REG_MIN_LEN, lens[k]);
            for (int i = 0; i < 18; i++) send_unit(16'(16'h0030 + i), 1'b0, i == 17);
            drain();
        end
    endtask

    function automatic logic [15:0] pick_bmp();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(16'h20, 16'h7E));
            1: return 16'($urandom_range(16'hA0, 16'h7FF));
            2: return 16'($urandom_range(16'h800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFD));
        endcase
    endfunction

    // One stream: mostly well-formed text, some breakers and raw noise
    task automatic random_stream(int n_units);
        bit big;
        bit lst;
        int r;
        int cp;
        big = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 2) == 0) send_unit(16'hFEFF, big, 1'b0);
        for (int i = 0; i < n_units; i++)
        begin
            r = $urandom_range(0, 99);
            lst = (i == n_units - 1);
            if (r < 70)
            begin
                send_unit(pick_bmp(), big, lst);
            end
            else if (r < 80)
            begin
                cp = $urandom_range(32'h10000, 32'h10FFFF) - 32'h10000;
                send_unit(16'hD800 | 16'(cp >> 10), big, 1'b0);
                send_unit(16'hDC00 | 16'(cp & 32'h3FF), big, lst);
            end
            else if (r < 86)
            begin
                send_unit(16'($urandom_range(0, 16'h1F)), big, lst);
            end
            else if (r < 93)
            begin
                case ($urandom_range(0, 3))
                    0: send_unit(16'($urandom_range(16'hD800, 16'hDFFF)), big, lst);
                    1: send_unit(16'($urandom_range(16'hFFFE, 16'hFFFF)), big, lst);
                    2: send_unit(16'($urandom_range(16'hFDD0, 16'hFDEF)), big, lst);
                    default: send_unit(16'($urandom_range(16'h7F, 16'h9F)), big, lst);
                endcase
            end
            else
            begin
                send_byte(8'($urandom), 1'b0);
                send_byte(8'($urandom), lst);
            end
        end
        if (n_units == 0) send_byte(8'($urandom), 1'b1);
    endtask

    task automatic test_random_text();
        while (bytes_sent < 340)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                drain();
                write_reg(u16rx_pkg::REG_MIN_LEN, 5'($urandom_range(0, 31)));
                write_reg(u16rx_pkg::REG_ENDIAN_MODE, 5'($urandom_range(0, 3)));
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                drain();
                write_reg(u16rx_pkg::REG_MIN_LEN, 5'($urandom_range(1, 6)));  // short runs
            end
            random_stream($urandom_range(0, 12));
        end
        drain();
    endtask

    // Receiver holds off while the sender keeps pushing a run of short releases
    task automatic test_backpressure();
        write_reg(u16rx_pkg::REG_MIN_LEN, 5'd1);
        write_reg(u16rx_pkg::REG_ENDIAN_MODE, 5'(u16rx_pkg::MODE_BOTH));
        hold_req++;
        for (int i = 0; i < 30; i++) send_unit(pick_bmp(), 1'b0, i == 29);
        drain();
    endtask

    // Last part: no idling on either side
    task automatic test_streaming_tail();
        gaps_on = 1'b0;
        write_reg(u16rx_pkg::REG_MIN_LEN, 5'd3);
        for (int i = 0; i < 4; i++) random_stream($urandom_range(3, 10));
    endtask

    initial
    begin
        clear_stream();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_run_boundaries();
        drain();
        test_surrogates();
        test_lane_select();
        test_min_len_extremes();
        test_backpressure();
        test_random_text();
        test_streaming_tail();

        // stimulus done: wait out the last beats, bounded
        s_tvalid <= 1'b0;
        fork
            wait (expected_beats.size() == 0);
            repeat (WATCHDOG_LIMIT) @(posedge clk);
        join_any
        disable fork;
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_beats.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches, %0d beats missing", mismatches, expected_beats.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
